// ===== hdl/swbrm_pkg.sv =====
// shared widths, register indexes and controller/datapath interface types
`default_nettype none

package swbrm_pkg;

    // ring depth default
    localparam int RING_DEPTH_DEF = 256;

    // field widths
    localparam int TIME_W  = 32;
    localparam int BYTES_W = 32;
    localparam int WIN_W   = 32;
    localparam int TPS_W   = 30;
    localparam int SPEED_W = 48;
    localparam int TOTAL_W = 40;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 1;

    // speed arithmetic: total times ticks per second, split in two halves
    localparam int PROD_W = TOTAL_W + TPS_W;
    localparam int HALF_W = TOTAL_W / 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 1'b1;

    // register reset values
    localparam logic [WIN_W-1:0] WIN_RESET = 32'd1000000;
    localparam logic [TPS_W-1:0] TPS_RESET = 30'd1000000;

    // transaction modes
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic latch;
        logic pop;
        logic append;
        logic mul_lo;
        logic mul_hi;
        logic div_init;
        logic div_step;
        logic load_out;
    } swbrm_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic mode_query;
        logic expire_hit;
        logic seen_add;
        logic out_free;
    } swbrm_status_t;

endpackage

`default_nettype wire

// ===== hdl/swbrm_ctrl.sv =====
// controller state machine: expiry loop, append, multiply and divide sequencing
`default_nettype none

module swbrm_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire swbrm_pkg::swbrm_status_t  status,
    output swbrm_pkg::swbrm_cmd_t          cmd
);
    import swbrm_pkg::*;

    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] S_IDLE     = 3'd0;
    localparam logic [STATE_W-1:0] S_EXPIRE   = 3'd1;
    localparam logic [STATE_W-1:0] S_APPEND   = 3'd2;
    localparam logic [STATE_W-1:0] S_MUL_LO   = 3'd3;
    localparam logic [STATE_W-1:0] S_MUL_HI   = 3'd4;
    localparam logic [STATE_W-1:0] S_DIV_INIT = 3'd5;
    localparam logic [STATE_W-1:0] S_DIV      = 3'd6;
    localparam logic [STATE_W-1:0] S_DONE     = 3'd7;

    localparam int DIV_CNT_W = $clog2(SPEED_W);
    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(SPEED_W - 1);

    logic [STATE_W-1:0]   state_reg, state_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready   = 1'b1;
                cmd.latch = s_valid;
                if (s_valid) begin
                    state_next = S_EXPIRE;
                end
            end
            S_EXPIRE: begin
                if (status.expire_hit) begin
                    cmd.pop = 1'b1;
                end else if (!status.mode_query) begin
                    state_next = S_APPEND;
                end else if (status.seen_add) begin
                    state_next = S_MUL_LO;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_APPEND: begin
                cmd.append = 1'b1;
                state_next = S_IDLE;
            end
            S_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/swbrm_datapath.sv =====
// datapath: entry ring memories, running sum, config, multiplier, divider, output register
`default_nettype none

module swbrm_datapath #(
    parameter int RING_DEPTH = swbrm_pkg::RING_DEPTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire swbrm_pkg::swbrm_cmd_t           cmd,
    output swbrm_pkg::swbrm_status_t             status,
    input  wire logic                            s_mode,
    input  wire logic [swbrm_pkg::TIME_W-1:0]    s_now_time,
    input  wire logic [swbrm_pkg::BYTES_W-1:0]   s_byte_amount,
    input  wire logic                            cfg_wr_en,
    input  wire logic [swbrm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [swbrm_pkg::CFG_W-1:0]     cfg_wr_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [swbrm_pkg::SPEED_W-1:0]        m_speed_bps,
    output logic [swbrm_pkg::TOTAL_W-1:0]        m_window_bytes,
    output logic                                 m_speed_valid,
    output logic                                 m_ring_overflowed
);
    import swbrm_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = BYTES_W + $clog2(RING_DEPTH);
    localparam int EXT_W = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W + 1;
    localparam int MUL_W = HALF_W + TPS_W;
    localparam int HI_W  = PROD_W - SPEED_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_DEPTH);

    // entry ring memories
    logic [TIME_W-1:0]  time_mem  [RING_DEPTH];
    logic [BYTES_W-1:0] bytes_mem [RING_DEPTH];

    logic [TIME_W-1:0]  rd_time_reg;
    logic [BYTES_W-1:0] rd_bytes_reg;

    logic [IDX_W-1:0] head_reg, head_next, head_inc;
    logic [IDX_W-1:0] tail_reg, tail_next, tail_inc;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             seen_reg, ovf_reg;
    logic             full;

    logic [WIN_W-1:0] win_reg;
    logic [TPS_W-1:0] tps_reg;

    logic               mode_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [BYTES_W-1:0] amount_reg;

    logic [EXT_W-1:0]   sum_ext;
    logic [TOTAL_W-1:0] total;

    logic [HALF_W-1:0] mul_a;
    logic [MUL_W-1:0]  mul_p;
    logic [PROD_W-1:0] prod_reg;

    logic [WIN_W-1:0]   div_w;
    logic [HI_W-1:0]    prod_hi;
    logic [WIN_W-1:0]   rem_reg;
    logic [SPEED_W-1:0] quot_reg;
    logic               sat_reg;
    logic [WIN_W:0]     trial, diff;
    logic               trial_ge;

    logic                 m_valid_reg;
    logic [SPEED_W-1:0]   speed_reg;
    logic [TOTAL_W-1:0]   bytes_out_reg;
    logic                 speed_valid_reg;
    logic                 ovf_out_reg;

    // ring pointer and count updates
    always_comb begin
        full      = (count_reg == FULL_CNT);
        head_inc  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
        tail_inc  = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
        head_next = head_reg;
        tail_next = tail_reg;
        count_next = count_reg;
        sum_next  = sum_reg;
        if (cmd.pop) begin
            head_next  = head_inc;
            count_next = count_reg - 1'b1;
            sum_next   = sum_reg - SUM_W'(rd_bytes_reg);
        end else if (cmd.append) begin
            tail_next = tail_inc;
            if (full) begin
                head_next = head_inc;
                sum_next  = sum_reg + SUM_W'(amount_reg) - SUM_W'(rd_bytes_reg);
            end else begin
                count_next = count_reg + 1'b1;
                sum_next   = sum_reg + SUM_W'(amount_reg);
            end
        end
    end

    // memory write at tail, registered read at the upcoming head
    always_ff @(posedge aclk) begin
        if (cmd.append) begin
            time_mem[tail_reg]  <= now_reg;
            bytes_mem[tail_reg] <= amount_reg;
        end
        rd_time_reg  <= time_mem[head_next];
        rd_bytes_reg <= bytes_mem[head_next];
    end

    // ring control state and sticky flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            seen_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            if (cmd.append) begin
                seen_reg <= 1'b1;
                if (full) begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= WIN_RESET;
            tps_reg <= TPS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_WINDOW_TICKS:     win_reg <= cfg_wr_data;
                CFG_TICKS_PER_SECOND: tps_reg <= cfg_wr_data[TPS_W-1:0];
                default: ;
            endcase
        end
    end

    // accepted transaction fields
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            mode_reg   <= s_mode;
            now_reg    <= s_now_time;
            amount_reg <= s_byte_amount;
        end
    end

    // saturated window total
    always_comb begin
        sum_ext = EXT_W'(sum_reg);
        total   = (|sum_ext[EXT_W-1:TOTAL_W]) ? '1 : sum_ext[TOTAL_W-1:0];
    end

    // total times ticks per second, low half then high half
    assign mul_a = cmd.mul_hi ? total[TOTAL_W-1:HALF_W] : total[HALF_W-1:0];
    assign mul_p = MUL_W'(mul_a) * MUL_W'(tps_reg);

    always_ff @(posedge aclk) begin
        if (cmd.mul_lo) begin
            prod_reg <= PROD_W'(mul_p);
        end else if (cmd.mul_hi) begin
            prod_reg <= prod_reg + (PROD_W'(mul_p) << HALF_W);
        end
    end

    // restoring divider, one quotient bit per cycle
    always_comb begin
        div_w    = (win_reg == '0) ? WIN_W'(1) : win_reg;
        prod_hi  = prod_reg[PROD_W-1:SPEED_W];
        trial    = {rem_reg, quot_reg[SPEED_W-1]};
        diff     = trial - {1'b0, div_w};
        trial_ge = (trial >= {1'b0, div_w});
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            // quotient reaches 2^48 exactly when the upper product bits reach the divisor
            sat_reg  <= (WIN_W'(prod_hi) >= div_w);
            rem_reg  <= WIN_W'(prod_hi);
            quot_reg <= prod_reg[SPEED_W-1:0];
        end else if (cmd.div_step) begin
            rem_reg  <= trial_ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
            quot_reg <= {quot_reg[SPEED_W-2:0], trial_ge};
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            speed_valid_reg <= seen_reg;
            ovf_out_reg     <= ovf_reg;
            if (!seen_reg) begin
                speed_reg     <= '0;
                bytes_out_reg <= '0;
            end else begin
                speed_reg     <= sat_reg ? '1 : quot_reg;
                bytes_out_reg <= total;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_speed_bps       = speed_reg;
    assign m_window_bytes    = bytes_out_reg;
    assign m_speed_valid     = speed_valid_reg;
    assign m_ring_overflowed = ovf_out_reg;

    // status toward the controller
    always_comb begin
        status.mode_query = (mode_reg == MODE_QUERY);
        status.expire_hit = (count_reg != '0) &&
                            (({1'b0, rd_time_reg} + {1'b0, win_reg}) < {1'b0, now_reg});
        status.seen_add   = seen_reg;
        status.out_free   = !m_valid_reg || m_ready;
    end

endmodule

`default_nettype wire

// ===== hdl/sliding_window_byte_rate_meter.sv =====
// add: expiry pops entries past the window, then the append, then ready for the next
// query: expiry pops, split multiply (low half, then high half), restoring divider, then
//   the result is loaded once the output register is free; before any add: no multiply or divide
// one transaction at a time; a result may wait in the output register while the next is taken
// reset: synchronous active low; clears pointers, count, sum, flags and config to defaults
// ring contents are not cleared; ready is high in the first cycle after reset
`default_nettype none

module sliding_window_byte_rate_meter #(
    parameter int RING_DEPTH = swbrm_pkg::RING_DEPTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_mode,
    input  wire logic [swbrm_pkg::TIME_W-1:0]    s_now_time,
    input  wire logic [swbrm_pkg::BYTES_W-1:0]   s_byte_amount,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [swbrm_pkg::SPEED_W-1:0]        m_speed_bps,
    output logic [swbrm_pkg::TOTAL_W-1:0]        m_window_bytes,
    output logic                                 m_speed_valid,
    output logic                                 m_ring_overflowed,
    input  wire logic                            cfg_wr_en,
    input  wire logic [swbrm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [swbrm_pkg::CFG_W-1:0]     cfg_wr_data
);
    import swbrm_pkg::*;

    swbrm_cmd_t    cmd;
    swbrm_status_t status;

    // sequencer
    swbrm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // ring, arithmetic and output register
    swbrm_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_mode            (s_mode),
        .s_now_time        (s_now_time),
        .s_byte_amount     (s_byte_amount),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_speed_bps       (m_speed_bps),
        .m_window_bytes    (m_window_bytes),
        .m_speed_valid     (m_speed_valid),
        .m_ring_overflowed (m_ring_overflowed)
    );

endmodule

`default_nettype wire

// ===== hdl/swbrm_checker.sv =====
// port-level checker for the rate meter and its bind
`default_nettype none

module swbrm_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic [swbrm_pkg::SPEED_W-1:0]   m_speed_bps,
    input wire logic [swbrm_pkg::TOTAL_W-1:0]   m_window_bytes,
    input wire logic                            m_speed_valid,
    input wire logic                            m_ring_overflowed
);
    import swbrm_pkg::*;

    logic ovf_seen_reg;

    // remember an overflow shown on an accepted result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_seen_reg <= 1'b0;
        end else if (m_valid && m_ready && m_ring_overflowed) begin
            ovf_seen_reg <= 1'b1;
        end
    end

    // a stalled result stays valid
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // one transaction at a time
    a_ready_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after acceptance");

    // no speed or bytes before the first add
    a_zero_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_speed_valid |-> (m_speed_bps == '0) && (m_window_bytes == '0))
        else $error("nonzero result while speed invalid");

    // overflow flag is sticky across results
    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ovf_seen_reg |-> m_ring_overflowed)
        else $error("ring overflow flag cleared");

endmodule

bind sliding_window_byte_rate_meter swbrm_checker u_swbrm_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_speed_bps       (m_speed_bps),
    .m_window_bytes    (m_window_bytes),
    .m_speed_valid     (m_speed_valid),
    .m_ring_overflowed (m_ring_overflowed)
);

`default_nettype wire

// ===== tb/sv/sliding_window_byte_rate_meter_test.sv =====
// self-checking testbench for the sliding-window byte-rate meter
module sliding_window_byte_rate_meter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import swbrm_pkg::*;

    localparam int RING_DEPTH = RING_DEPTH_DEF;
    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
    localparam logic [WIN_W-1:0] WIN_MAX = '1;
    localparam logic [TPS_W-1:0] TPS_MAX = 30'd1000000000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 320;
    localparam int DRAIN_LIMIT = 50000;
    localparam int STEP_CAP = 1 << 20;
    localparam int EXP_DEPTH = 16;

    // one expected query result
    typedef struct packed {
        logic [SPEED_W-1:0] speed_bps;
        logic [TOTAL_W-1:0] window_bytes;
        logic               speed_valid;
        logic               ring_overflowed;
    } rate_result_t;

    // dut ports
    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_mode = MODE_ADD;
    logic [TIME_W-1:0]    s_now_time = '0;
    logic [BYTES_W-1:0]   s_byte_amount = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [SPEED_W-1:0]   m_speed_bps;
    logic [TOTAL_W-1:0]   m_window_bytes;
    logic                 m_speed_valid;
    logic                 m_ring_overflowed;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW_TICKS;
    logic [CFG_W-1:0]     cfg_wr_data = '0;

    // predictor state, mirrors the block after reset
    logic [TIME_W-1:0]  ring_time [RING_DEPTH];
    logic [BYTES_W-1:0] ring_bytes [RING_DEPTH];
    int unsigned        head_ptr = 0;
    int unsigned        live_count = 0;
    longint unsigned    byte_sum = 0;
    bit                 any_add = 1'b0;
    bit                 evicted = 1'b0;
    logic [WIN_W-1:0]   win_cfg = WIN_RESET;
    logic [TPS_W-1:0]   tps_cfg = TPS_RESET;

    // expected results in order, written and read by running counters
    rate_result_t       exp_mem [EXP_DEPTH];
    int unsigned        exp_wr_cnt = 0;
    int unsigned        exp_rd_cnt = 0;
    int                 err_count = 0;
    logic [TIME_W-1:0]  now_t = '0;
    bit                 send_gaps_on = 1'b1;
    bit                 recv_gaps_on = 1'b1;
    int                 hold_reqs = 0;

    sliding_window_byte_rate_meter u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_now_time        (s_now_time),
        .s_byte_amount     (s_byte_amount),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_speed_bps       (m_speed_bps),
        .m_window_bytes    (m_window_bytes),
        .m_speed_valid     (m_speed_valid),
        .m_ring_overflowed (m_ring_overflowed),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // overall time limit
    initial begin : run_limit
        #25_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // drop the oldest ring entry
    function automatic void retire_oldest();
        byte_sum -= ring_bytes[head_ptr];
        head_ptr = (head_ptr + 1) % RING_DEPTH;
        live_count--;
    endfunction

    // update the predicted state for one transaction, queue the result of a query
    function automatic void rate_predict(logic mode, logic [TIME_W-1:0] t,
                                         logic [BYTES_W-1:0] amount);
        rate_result_t        res;
        logic [TOTAL_W-1:0]  total;
        logic [95:0]         quo;
        logic [WIN_W-1:0]    win_eff;
        int unsigned         slot;
        // expiry at the head, time plus window without wrap
        while (live_count != 0 &&
               ({1'b0, ring_time[head_ptr]} + {1'b0, win_cfg}) < {1'b0, t})
            retire_oldest();
        if (mode == MODE_ADD) begin
            any_add = 1'b1;
            if (live_count >= RING_DEPTH) begin
                retire_oldest();
                evicted = 1'b1;
            end
            slot = (head_ptr + live_count) % RING_DEPTH;
            ring_time[slot] = t;
            ring_bytes[slot] = amount;
            live_count++;
            byte_sum += amount;
        end else begin
            total = (byte_sum > TOTAL_MAX) ? TOTAL_MAX : byte_sum[TOTAL_W-1:0];
            res = '0;
            if (any_add) begin
                win_eff = (win_cfg == '0) ? WIN_W'(1) : win_cfg;
                quo = (96'(total) * 96'(tps_cfg)) / 96'(win_eff);
                res.speed_bps = (quo > 96'(SPEED_MAX)) ? SPEED_MAX : quo[SPEED_W-1:0];
                res.window_bytes = total;
                res.speed_valid = 1'b1;
            end
            res.ring_overflowed = evicted;
            exp_mem[exp_wr_cnt % EXP_DEPTH] = res;
            exp_wr_cnt++;
        end
    endfunction

    // compare each result transaction with the oldest expectation
    always @(posedge aclk) begin : result_check
        rate_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (exp_wr_cnt == exp_rd_cnt) begin
                $error("result transaction with no expectation pending");
                err_count++;
            end else begin
                want = exp_mem[exp_rd_cnt % EXP_DEPTH];
                exp_rd_cnt++;
                if (m_speed_bps !== want.speed_bps) begin
                    $error("speed_bps: expected %0d, actual %0d", want.speed_bps, m_speed_bps);
                    err_count++;
                end
                if (m_window_bytes !== want.window_bytes) begin
                    $error("window_bytes: expected %0d, actual %0d",
                           want.window_bytes, m_window_bytes);
                    err_count++;
                end
                if (m_speed_valid !== want.speed_valid) begin
                    $error("speed_valid: expected %0d, actual %0d",
                           want.speed_valid, m_speed_valid);
                    err_count++;
                end
                if (m_ring_overflowed !== want.ring_overflowed) begin
                    $error("ring_overflowed: expected %0d, actual %0d",
                           want.ring_overflowed, m_ring_overflowed);
                    err_count++;
                end
            end
        end
    end

    // result receiver: random gaps per transaction, long hold on request
    initial begin : result_sink
        int gap;
        int hold_seen;
        hold_seen = 0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = recv_gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready) && hold_seen == hold_reqs) @(posedge aclk);
        end
    end

    // offer one transaction and wait for its acceptance
    task automatic send_item(input logic mode, input logic [TIME_W-1:0] t,
                             input logic [BYTES_W-1:0] amount);
        int gap;
        gap = send_gaps_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_now_time <= t;
        s_byte_amount <= amount;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        rate_predict(mode, t, amount);
    endtask

    // wait until every result is in and the block has finished its last add
    task automatic settle_block();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (exp_wr_cnt != exp_rd_cnt && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (exp_wr_cnt != exp_rd_cnt) begin
            $error("%0d expected results never arrived", exp_wr_cnt - exp_rd_cnt);
            err_count++;
            exp_rd_cnt = exp_wr_cnt;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write, block must be idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_WINDOW_TICKS)
            win_cfg = value;
        else
            tps_cfg = value[TPS_W-1:0];
    endtask

    task automatic set_rates(input logic [WIN_W-1:0] win, input logic [TPS_W-1:0] tps);
        settle_block();
        write_reg(CFG_WINDOW_TICKS, win);
        write_reg(CFG_TICKS_PER_SECOND, CFG_W'(tps));
    endtask

    // time step scaled to the window so entries pile up and expire in bursts
    function automatic int unsigned draw_step(longint unsigned win);
        longint unsigned span;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            span = 0;
        else if (pick < 75)
            span = win / 8;
        else if (pick < 95)
            span = win;
        else
            span = 2 * win;
        if (span > STEP_CAP)
            span = STEP_CAP;
        return $urandom_range(0, 32'(span));
    endfunction

    function automatic logic [BYTES_W-1:0] draw_amount();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return '0;
        else if (pick < 20)
            return BYTES_MAX;
        else if (pick < 60)
            return $urandom_range(0, 1500);
        else
            return $urandom;
    endfunction

    // move the current time forward, clamped at the top of the range
    function automatic void advance_time(int unsigned step);
        longint unsigned nxt;
        nxt = longint'(now_t) + step;
        now_t = (nxt > TIME_MAX) ? TIME_MAX : nxt[TIME_W-1:0];
    endfunction

    // queries before and after the first add, with reset register values
    task automatic test_reset_defaults();
        send_item(MODE_QUERY, 32'd0, BYTES_MAX);
        send_item(MODE_ADD, 32'd0, 32'd1500);
        send_item(MODE_QUERY, 32'd0, 32'd0);
    endtask

    // entries exactly at the window edge stay, one tick later they go
    task automatic test_window_boundary();
        set_rates(32'd1000, 30'd1000000);
        send_item(MODE_ADD, 32'd10, 32'd0);
        send_item(MODE_ADD, 32'd10, BYTES_MAX);
        send_item(MODE_QUERY, 32'd1010, 32'd0);
        send_item(MODE_QUERY, 32'd1011, 32'd0);
        send_item(MODE_ADD, 32'd1011, 32'd5);
        send_item(MODE_QUERY, 32'd1011, 32'd0);
    endtask

    // time plus window beyond 32 bits, extreme register values
    task automatic test_time_extremes();
        set_rates(WIN_MAX, 30'd1);
        send_item(MODE_ADD, TIME_MAX - 32'd15, BYTES_MAX);
        send_item(MODE_QUERY, TIME_MAX, 32'd0);
        set_rates(32'd1, TPS_MAX);
        send_item(MODE_QUERY, TIME_MAX, 32'd0);
    endtask

    // saturated speed, then a query with time going backwards
    task automatic test_time_backwards();
        send_item(MODE_ADD, 32'd100, BYTES_MAX);
        send_item(MODE_ADD, 32'd100, BYTES_MAX);
        send_item(MODE_QUERY, 32'd100, 32'd0);
        send_item(MODE_QUERY, 32'd50, 32'd0);
        send_item(MODE_QUERY, 32'd102, 32'd0);
        now_t = 32'd102;
    endtask

    // random adds and queries under one register setting
    task automatic test_random_traffic(input logic [WIN_W-1:0] win,
                                       input logic [TPS_W-1:0] tps,
                                       input logic [TIME_W-1:0] base, input int count);
        logic [TIME_W-1:0] t;
        logic              mode;
        set_rates(win, tps);
        if (now_t < base)
            now_t = base;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                send_gaps_on = ($urandom_range(0, 3) != 0);
                recv_gaps_on = ($urandom_range(0, 3) != 0);
            end
            advance_time(draw_step(win));
            mode = ($urandom_range(0, 99) < 35) ? MODE_QUERY : MODE_ADD;
            t = now_t;
            // rare query behind the current time
            if (mode == MODE_QUERY && now_t > 64 && $urandom_range(0, 49) == 0)
                t = now_t - $urandom_range(1, 64);
            send_item(mode, t, draw_amount());
        end
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_output_stall();
        set_rates(32'd5000, 30'd1000000);
        if (now_t < 32'hA000_0000)
            now_t = 32'hA000_0000;
        send_gaps_on = 1'b0;
        recv_gaps_on = 1'b1;
        send_item(MODE_ADD, now_t, 32'd1000);
        hold_reqs <= hold_reqs + 1;
        for (int i = 0; i < 40; i++) begin
            advance_time($urandom_range(0, 300));
            send_item(($urandom_range(0, 3) != 0) ? MODE_QUERY : MODE_ADD, now_t,
                      draw_amount());
        end
    endtask

    // endless window so the ring fills and evicts
    task automatic test_ring_overflow();
        set_rates(WIN_MAX, TPS_MAX);
        if (now_t < 32'hC000_0000)
            now_t = 32'hC000_0000;
        send_gaps_on = 1'b1;
        recv_gaps_on = 1'b1;
        for (int i = 0; i < 300; i++) begin
            advance_time(draw_step(STEP_CAP));
            send_item((i % 20 == 19) ? MODE_QUERY : MODE_ADD, now_t, draw_amount());
        end
    endtask

    // test sequence
    initial begin : test_sequence
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_window_boundary();
        test_time_extremes();
        test_time_backwards();
        test_random_traffic(32'd1000, 30'd1000000, 32'h0000_0000, 150);
        test_random_traffic(32'd1, 30'd1, 32'h2000_0000, 150);
        test_random_traffic(32'd16, TPS_MAX, 32'h4000_0000, 150);
        test_random_traffic($urandom_range(1, 1 << 20),
                            TPS_W'($urandom_range(1, 1000000000)),
                            32'h6000_0000, 150);
        test_random_traffic(32'd100000, TPS_MAX, 32'h8000_0000, 150);
        test_output_stall();
        test_ring_overflow();
        test_random_traffic($urandom_range(1 << 16, 32'hFFFF_FFFF),
                            TPS_W'($urandom_range(1, 1000000000)), 32'hF000_0000, 100);
        settle_block();
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
